// ===== rtl/lrgd_pkg.sv =====
// Shared types, constants and helpers for the gradient descent regression block.
package lrgd_pkg;

    localparam int MAX_SAMPLES  = 1024;
    localparam int MAX_FEATURES = 8;
    localparam int ROW_W        = $clog2(MAX_SAMPLES);
    localparam int CNT_W        = ROW_W + 1;
    localparam int COL_W        = 3;
    localparam int CIDX_W       = 4;
    localparam int FIU_W        = 4;
    localparam logic signed [63:0] GCLAMP = 64'sh3FFF_FFFF_FFFF_FFFF;

    typedef logic signed [31:0] t_word;

    typedef enum logic [1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_TRAIN   = 2'd1,
        FUNC_PREDICT = 2'd2,
        FUNC_CLEAR   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        KIND_COEF   = 2'd0,
        KIND_PRED   = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CFG_LR    = 2'd0,
        CFG_LIMIT = 2'd1,
        CFG_TOL   = 2'd2,
        CFG_FIU   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        POP_NONE,
        POP_DOT,
        POP_GRAD
    } t_pop;

    typedef enum logic [1:0] {
        VSEL_COEF,
        VSEL_PRED,
        VSEL_ZERO
    } t_vsel;

    typedef struct packed {
        logic               load;
        logic               clear;
        logic               cap;
        logic               coef_clr;
        logic               epoch_init;
        logic               acc_init;
        t_pop               pop;
        logic               src_in;
        logic [COL_W-1:0]   col;
        logic [CIDX_W-1:0]  cidx;
        logic [ROW_W-1:0]   row;
        logic               err;
        logic               div_start;
        logic               upd_grad;
        logic               upd_mul;
        logic               upd_apply;
        logic               emit;
        t_kind              kind;
        logic               last;
        logic [15:0]        epochs;
        logic               conv;
        t_vsel              vsel;
    } t_dp_cmd;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic               busy;
        logic               div_busy;
        logic               converged;
        logic               out_free;
        logic [CNT_W-1:0]   count;
    } t_dp_stat;

    function automatic t_word sat32(input logic signed [63:0] x);
        if (x > 64'sh0000_0000_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (x < -64'sh0000_0000_8000_0000)
            return -32'sh8000_0000;
        return x[31:0];
    endfunction

    function automatic logic [CIDX_W-1:0] used_features(input logic [FIU_W-1:0] fiu);
        if (fiu == '0)
            return CIDX_W'(1);
        if (fiu > FIU_W'(MAX_FEATURES))
            return CIDX_W'(MAX_FEATURES);
        return fiu;
    endfunction

endpackage

// ===== rtl/linear_regression_gradient_descent.sv =====
// Top level: stream ports, configuration registers, controller and datapath.
// Loads and clears are taken back to back; a load into a full store is rejected.
// Predict: the result is emitted once the dot product over the n features in use has left
// the single MAC pipeline, shared with training; a new request is taken only after emission.
// Train: each epoch passes over all m rows, then divides and updates each of the n+1
// coefficients. Synchronous active-low reset clears control, sample count and coefficients;
// the sample memories need no clearing since only rows below the count are read.
module linear_regression_gradient_descent (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [287:0]  s_axis_tdata,   // feat_0 .. feat_7, target (32 bits each)
    input  logic [1:0]    s_axis_tuser,   // func
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [55:0]   m_axis_tdata,   // index[3:0], value[35:4], epochs_run[51:36],
                                          // converged[52], zero pad
    output logic [1:0]    m_axis_tuser,   // kind
    output logic          m_axis_tlast,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [30:0]   i_cfg_data
);
    logic [15:0]           r_lr;
    logic [15:0]           r_limit;
    logic [30:0]           r_tol;
    logic [3:0]            r_fiu;

    lrgd_pkg::t_word       feat [lrgd_pkg::MAX_FEATURES];
    lrgd_pkg::t_dp_cmd     cmd;
    lrgd_pkg::t_dp_stat    stat;
    lrgd_pkg::t_kind       o_kind;
    logic [3:0]            o_index;
    lrgd_pkg::t_word       o_value;
    logic [15:0]           o_epochs;
    logic                  o_conv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr    <= 16'd655;
            r_limit <= 16'd1000;
            r_tol   <= 31'd66;
            r_fiu   <= 4'd8;
        end else if (i_cfg_we) begin
            case (lrgd_pkg::t_cfg_idx'(i_cfg_idx))
                lrgd_pkg::CFG_LR:    r_lr    <= i_cfg_data[15:0];
                lrgd_pkg::CFG_LIMIT: r_limit <= i_cfg_data[15:0];
                lrgd_pkg::CFG_TOL:   r_tol   <= i_cfg_data;
                lrgd_pkg::CFG_FIU:   r_fiu   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int b = 0; b < lrgd_pkg::MAX_FEATURES; b++)
            feat[b] = s_axis_tdata[32*b +: 32];
    end

    lrgd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_func        (lrgd_pkg::t_func'(s_axis_tuser)),
        .o_in_ready    (s_axis_tready),
        .i_epoch_limit (r_limit),
        .i_fiu         (r_fiu),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    lrgd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_feat      (feat),
        .i_target    (s_axis_tdata[287:256]),
        .i_lr        (r_lr),
        .i_tol       (r_tol),
        .i_out_ready (m_axis_tready),
        .o_stat      (stat),
        .o_valid     (m_axis_tvalid),
        .o_kind      (o_kind),
        .o_index     (o_index),
        .o_value     (o_value),
        .o_last      (m_axis_tlast),
        .o_epochs    (o_epochs),
        .o_conv      (o_conv)
    );

    assign m_axis_tuser = o_kind;
    assign m_axis_tdata = {3'b000, o_conv, o_epochs, o_value, o_index};
endmodule

// ===== rtl/lrgd_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
module lrgd_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [62:0]                 i_dividend,
    input  logic [lrgd_pkg::CNT_W-1:0]  i_divisor,
    output logic                        o_busy,
    output logic [62:0]                 o_quotient
);
    logic [62:0]                r_dq;
    logic [lrgd_pkg::CNT_W-1:0] r_rem;
    logic [lrgd_pkg::CNT_W-1:0] r_dvs;
    logic [5:0]                 r_cnt;
    logic                       r_busy;
    logic [lrgd_pkg::CNT_W:0]   rem_sh;
    logic                       fits;

    assign rem_sh = {r_rem, r_dq[62]};
    assign fits   = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd62;
        end else if (r_busy) begin
            if (r_cnt == '0)
                r_busy <= 1'b0;
            r_cnt <= r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq  <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_dq  <= {r_dq[61:0], fits};
            r_rem <= fits ? lrgd_pkg::CNT_W'(rem_sh - {1'b0, r_dvs})
                          : lrgd_pkg::CNT_W'(rem_sh);
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_dq;
endmodule

// ===== rtl/lrgd_dp.sv =====
// Datapath: sample memories, MAC pipeline, gradient sums, coefficient update, result register.
module lrgd_dp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  lrgd_pkg::t_dp_cmd       i_cmd,
    input  lrgd_pkg::t_word         i_feat [lrgd_pkg::MAX_FEATURES],
    input  lrgd_pkg::t_word         i_target,
    input  logic [15:0]             i_lr,
    input  logic [30:0]             i_tol,
    input  logic                    i_out_ready,
    output lrgd_pkg::t_dp_stat      o_stat,
    output logic                    o_valid,
    output lrgd_pkg::t_kind         o_kind,
    output logic [3:0]              o_index,
    output lrgd_pkg::t_word         o_value,
    output logic                    o_last,
    output logic [15:0]             o_epochs,
    output logic                    o_conv
);
    localparam int NF = lrgd_pkg::MAX_FEATURES;

    lrgd_pkg::t_word             r_fmem [NF][lrgd_pkg::MAX_SAMPLES];
    lrgd_pkg::t_word             r_tmem [lrgd_pkg::MAX_SAMPLES];
    logic [lrgd_pkg::CNT_W-1:0]  r_count;

    lrgd_pkg::t_word             r_in_feat [NF];
    lrgd_pkg::t_word             r_fbank [NF];
    lrgd_pkg::t_word             r_tgt;
    lrgd_pkg::t_word             r_coef [NF+1];
    logic signed [63:0]          r_gsum [NF+1];
    logic signed [63:0]          r_acc;
    lrgd_pkg::t_word             r_err;

    logic                        r_v1, r_v2;
    lrgd_pkg::t_pop              r_pop1, r_pop2;
    logic [lrgd_pkg::COL_W-1:0]  r_col1, r_col2;
    logic                        r_src1;
    lrgd_pkg::t_word             r_op1;
    logic signed [63:0]          r_prod;

    logic                        r_gneg;
    lrgd_pkg::t_word             r_grad;
    logic signed [32:0]          r_step;
    logic [63:0]                 r_sq;
    logic [63:0]                 r_norm2;
    logic [61:0]                 r_tol2;

    logic                        r_ovalid;
    lrgd_pkg::t_kind             r_okind;
    logic [3:0]                  r_oindex;
    lrgd_pkg::t_word             r_ovalue;
    logic                        r_olast;
    logic [15:0]                 r_oepochs;
    logic                        r_oconv;

    logic [lrgd_pkg::CIDX_W-1:0] gidx;
    logic signed [63:0]          g_rd;
    logic signed [63:0]          g_cl;
    lrgd_pkg::t_word             c_rd;
    lrgd_pkg::t_word             x_sel;
    logic signed [63:0]          prod_q;
    lrgd_pkg::t_word             err_v;
    logic                        div_busy;
    logic [62:0]                 quot;
    lrgd_pkg::t_word             grad_v;
    logic signed [48:0]          step_full;
    logic [64:0]                 norm_sum;
    lrgd_pkg::t_word             val_sel;

    assign c_rd   = r_coef[i_cmd.cidx];
    assign gidx   = r_v2 ? lrgd_pkg::CIDX_W'(r_col2) + lrgd_pkg::CIDX_W'(1) : i_cmd.cidx;
    assign g_rd   = r_gsum[gidx];
    assign prod_q = r_prod >>> 16;
    assign x_sel  = r_src1 ? r_in_feat[r_col1] : r_fbank[r_col1];
    assign err_v  = lrgd_pkg::sat32(64'(lrgd_pkg::sat32(r_acc)) - 64'(r_tgt));

    always_comb begin
        g_cl = g_rd;
        if (g_rd > lrgd_pkg::GCLAMP)
            g_cl = lrgd_pkg::GCLAMP;
        else if (g_rd < -lrgd_pkg::GCLAMP)
            g_cl = -lrgd_pkg::GCLAMP;
    end

    lrgd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (g_cl[63] ? 63'(-g_cl) : 63'(g_cl)),
        .i_divisor  (r_count),
        .o_busy     (div_busy),
        .o_quotient (quot)
    );

    // doubled quotient, signed, saturated
    always_comb begin
        if (quot >= 63'h4000_0000)
            grad_v = r_gneg ? -32'sh8000_0000 : 32'sh7FFF_FFFF;
        else if (r_gneg)
            grad_v = -$signed({1'b0, quot[29:0], 1'b0});
        else
            grad_v = $signed({1'b0, quot[29:0], 1'b0});
    end

    assign step_full = $signed({1'b0, i_lr}) * r_grad;
    assign norm_sum  = {1'b0, r_norm2} + {1'b0, r_sq};

    always_comb begin
        case (i_cmd.vsel)
            lrgd_pkg::VSEL_COEF: val_sel = c_rd;
            lrgd_pkg::VSEL_PRED: val_sel = lrgd_pkg::sat32(r_acc);
            default:             val_sel = '0;
        endcase
    end

    // sample memories: one bank per feature column
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int b = 0; b < NF; b++)
                r_fmem[b][r_count[lrgd_pkg::ROW_W-1:0]] <= i_feat[b];
            r_tmem[r_count[lrgd_pkg::ROW_W-1:0]] <= i_target;
        end
        for (int b = 0; b < NF; b++)
            r_fbank[b] <= r_fmem[b][i_cmd.row];
        r_tgt <= r_tmem[i_cmd.row];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_count <= '0;
        else if (i_cmd.clear)
            r_count <= '0;
        else if (i_cmd.load)
            r_count <= r_count + lrgd_pkg::CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap)
            r_in_feat <= i_feat;
    end

    // MAC pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.pop != lrgd_pkg::POP_NONE;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pop1 <= i_cmd.pop;
        r_col1 <= i_cmd.col;
        r_src1 <= i_cmd.src_in;
        r_op1  <= (i_cmd.pop == lrgd_pkg::POP_DOT) ? c_rd : r_err;
        r_pop2 <= r_pop1;
        r_col2 <= r_col1;
        r_prod <= x_sel * r_op1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_init)
            r_acc <= 64'(r_coef[0]);
        else if (r_v2 && r_pop2 == lrgd_pkg::POP_DOT)
            r_acc <= r_acc + prod_q;
        if (i_cmd.err)
            r_err <= err_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NF; k++)
                r_gsum[k] <= '0;
        end else if (i_cmd.epoch_init) begin
            for (int k = 0; k <= NF; k++)
                r_gsum[k] <= '0;
        end else if (i_cmd.err) begin
            r_gsum[0] <= r_gsum[0] + 64'(err_v);
        end else if (r_v2 && r_pop2 == lrgd_pkg::POP_GRAD) begin
            r_gsum[gidx] <= g_rd + prod_q;
        end
    end

    // coefficient update sequence
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start)
            r_gneg <= g_cl[63];
        if (i_cmd.upd_grad)
            r_grad <= grad_v;
        if (i_cmd.upd_mul) begin
            r_step <= 33'(step_full >>> 16);
            r_sq   <= 64'(r_grad * r_grad);
        end
        r_tol2 <= i_tol * i_tol;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NF; k++)
                r_coef[k] <= '0;
            r_norm2 <= '0;
        end else begin
            if (i_cmd.coef_clr) begin
                for (int k = 0; k <= NF; k++)
                    r_coef[k] <= '0;
            end else if (i_cmd.upd_apply) begin
                r_coef[i_cmd.cidx] <= lrgd_pkg::sat32(64'(c_rd) - 64'(r_step));
            end
            if (i_cmd.epoch_init)
                r_norm2 <= '0;
            else if (i_cmd.upd_apply)
                r_norm2 <= norm_sum[64] ? '1 : norm_sum[63:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_ovalid <= 1'b0;
        else if (i_cmd.emit)
            r_ovalid <= 1'b1;
        else if (i_out_ready)
            r_ovalid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_okind   <= i_cmd.kind;
            r_oindex  <= i_cmd.cidx;
            r_ovalue  <= val_sel;
            r_olast   <= i_cmd.last;
            r_oepochs <= i_cmd.epochs;
            r_oconv   <= i_cmd.conv;
        end
    end

    assign o_stat.full      = r_count == lrgd_pkg::CNT_W'(lrgd_pkg::MAX_SAMPLES);
    assign o_stat.empty     = r_count == '0;
    assign o_stat.busy      = r_v1 | r_v2;
    assign o_stat.div_busy  = div_busy;
    assign o_stat.converged = r_norm2 < {2'b0, r_tol2};
    assign o_stat.out_free  = !r_ovalid || i_out_ready;
    assign o_stat.count     = r_count;

    assign o_valid  = r_ovalid;
    assign o_kind   = r_okind;
    assign o_index  = r_oindex;
    assign o_value  = r_ovalue;
    assign o_last   = r_olast;
    assign o_epochs = r_oepochs;
    assign o_conv   = r_oconv;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= lrgd_pkg::CNT_W'(lrgd_pkg::MAX_SAMPLES))
        else $error("sample count beyond store depth");
    a_div_idle_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !(r_v1 || r_v2) && !div_busy)
        else $error("divider started with MAC pipeline or divider active");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_ovalid || i_out_ready))
        else $error("result overwritten before it was taken");
endmodule

// ===== rtl/lrgd_ctrl.sv =====
// Controller: sequences loads, training epochs, coefficient updates and result emission.
module lrgd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  lrgd_pkg::t_func      i_func,
    output logic                 o_in_ready,
    input  logic [15:0]          i_epoch_limit,
    input  logic [3:0]           i_fiu,
    input  lrgd_pkg::t_dp_stat   i_stat,
    output lrgd_pkg::t_dp_cmd    o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE, S_T_INIT, S_E_START, S_R_INIT, S_R_DOT, S_R_DWAIT, S_R_ERR,
        S_R_GRAD, S_R_GWAIT, S_U_DIV, S_U_DWAIT, S_U_GRAD, S_U_MUL, S_U_APPLY,
        S_E_END, S_T_EMIT, S_P_INIT, S_P_DOT, S_P_WAIT, S_P_EMIT, S_REJ
    } t_state;

    t_state                       r_state;
    logic [lrgd_pkg::ROW_W-1:0]   r_row;
    logic [lrgd_pkg::COL_W-1:0]   r_col;
    logic [lrgd_pkg::CIDX_W-1:0]  r_k;
    logic [15:0]                  r_epoch;
    logic                         r_conv;

    logic [lrgd_pkg::CIDX_W-1:0]  n;
    logic [lrgd_pkg::COL_W-1:0]   col_last;
    logic                         accept;
    logic                         row_last;
    logic [15:0]                  n_epoch;

    assign n        = lrgd_pkg::used_features(i_fiu);
    assign col_last = lrgd_pkg::COL_W'(n - lrgd_pkg::CIDX_W'(1));
    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign row_last = (lrgd_pkg::CNT_W'(r_row) + lrgd_pkg::CNT_W'(1)) == i_stat.count;
    assign n_epoch  = r_epoch + 16'd1;
    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        o_cmd        = '0;
        o_cmd.pop    = lrgd_pkg::POP_NONE;
        o_cmd.kind   = lrgd_pkg::KIND_COEF;
        o_cmd.vsel   = lrgd_pkg::VSEL_ZERO;
        o_cmd.col    = r_col;
        o_cmd.row    = r_row;
        o_cmd.cidx   = r_k;
        o_cmd.cap    = accept;
        o_cmd.load   = accept && i_func == lrgd_pkg::FUNC_LOAD && !i_stat.full;
        o_cmd.clear  = accept && i_func == lrgd_pkg::FUNC_CLEAR;
        case (r_state)
            S_T_INIT:  o_cmd.coef_clr   = 1'b1;
            S_E_START: o_cmd.epoch_init = 1'b1;
            S_R_INIT, S_P_INIT: o_cmd.acc_init = 1'b1;
            S_R_DOT, S_P_DOT: begin
                o_cmd.pop    = lrgd_pkg::POP_DOT;
                o_cmd.src_in = r_state == S_P_DOT;
                o_cmd.cidx   = lrgd_pkg::CIDX_W'(r_col) + lrgd_pkg::CIDX_W'(1);
            end
            S_R_ERR:   o_cmd.err       = 1'b1;
            S_R_GRAD:  o_cmd.pop       = lrgd_pkg::POP_GRAD;
            S_U_DIV:   o_cmd.div_start = 1'b1;
            S_U_GRAD:  o_cmd.upd_grad  = 1'b1;
            S_U_MUL:   o_cmd.upd_mul   = 1'b1;
            S_U_APPLY: o_cmd.upd_apply = 1'b1;
            S_T_EMIT: begin
                o_cmd.emit   = i_stat.out_free;
                o_cmd.vsel   = lrgd_pkg::VSEL_COEF;
                o_cmd.last   = r_k == n;
                o_cmd.epochs = r_epoch;
                o_cmd.conv   = r_conv;
            end
            S_P_EMIT: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.kind = lrgd_pkg::KIND_PRED;
                o_cmd.vsel = lrgd_pkg::VSEL_PRED;
                o_cmd.cidx = '0;
                o_cmd.last = 1'b1;
            end
            S_REJ: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.kind = lrgd_pkg::KIND_REJECT;
                o_cmd.cidx = '0;
                o_cmd.last = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_k     <= '0;
            r_epoch <= '0;
            r_conv  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_col <= '0;
                    if (accept) begin
                        case (i_func)
                            lrgd_pkg::FUNC_LOAD:    if (i_stat.full) r_state <= S_REJ;
                            lrgd_pkg::FUNC_TRAIN:   r_state <= S_T_INIT;
                            lrgd_pkg::FUNC_PREDICT: r_state <= S_P_INIT;
                            default: ;
                        endcase
                    end
                end
                S_T_INIT: begin
                    r_epoch <= '0;
                    r_conv  <= 1'b0;
                    r_k     <= '0;
                    if (i_stat.empty || i_epoch_limit == '0)
                        r_state <= S_T_EMIT;
                    else
                        r_state <= S_E_START;
                end
                S_E_START: begin
                    r_row   <= '0;
                    r_state <= S_R_INIT;
                end
                S_R_INIT: begin
                    r_col   <= '0;
                    r_state <= S_R_DOT;
                end
                S_R_DOT: begin
                    r_col <= r_col + lrgd_pkg::COL_W'(1);
                    if (r_col == col_last)
                        r_state <= S_R_DWAIT;
                end
                S_R_DWAIT: if (!i_stat.busy) r_state <= S_R_ERR;
                S_R_ERR: begin
                    r_col   <= '0;
                    r_state <= S_R_GRAD;
                end
                S_R_GRAD: begin
                    r_col <= r_col + lrgd_pkg::COL_W'(1);
                    if (r_col == col_last)
                        r_state <= S_R_GWAIT;
                end
                S_R_GWAIT: begin
                    if (!i_stat.busy) begin
                        if (row_last) begin
                            r_k     <= '0;
                            r_state <= S_U_DIV;
                        end else begin
                            r_row   <= r_row + lrgd_pkg::ROW_W'(1);
                            r_state <= S_R_INIT;
                        end
                    end
                end
                S_U_DIV:   r_state <= S_U_DWAIT;
                S_U_DWAIT: if (!i_stat.div_busy) r_state <= S_U_GRAD;
                S_U_GRAD:  r_state <= S_U_MUL;
                S_U_MUL:   r_state <= S_U_APPLY;
                S_U_APPLY: begin
                    if (r_k == n) begin
                        r_state <= S_E_END;
                    end else begin
                        r_k     <= r_k + lrgd_pkg::CIDX_W'(1);
                        r_state <= S_U_DIV;
                    end
                end
                S_E_END: begin
                    r_epoch <= n_epoch;
                    if (i_stat.converged || n_epoch == i_epoch_limit) begin
                        r_conv  <= i_stat.converged;
                        r_k     <= '0;
                        r_state <= S_T_EMIT;
                    end else begin
                        r_state <= S_E_START;
                    end
                end
                S_T_EMIT: begin
                    if (i_stat.out_free) begin
                        r_k <= r_k + lrgd_pkg::CIDX_W'(1);
                        if (r_k == n)
                            r_state <= S_IDLE;
                    end
                end
                S_P_INIT: begin
                    r_col   <= '0;
                    r_state <= S_P_DOT;
                end
                S_P_DOT: begin
                    r_col <= r_col + lrgd_pkg::COL_W'(1);
                    if (r_col == col_last)
                        r_state <= S_P_WAIT;
                end
                S_P_WAIT: if (!i_stat.busy) r_state <= S_P_EMIT;
                S_P_EMIT, S_REJ: if (i_stat.out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
